[src/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the amicable pair tester.
// ----------------------------------------------------------------------------
package apt_pkg;

	// Fixed widths of the item fields.
	localparam int IN_BITS  = 16;
	localparam int SUM_BITS_OUT = 20;

	// Headroom of a divisor sum above the width of the number itself.
	localparam int SUM_EXTRA = 4;

	// One input item: the pair under test.
	typedef struct packed {
		logic [IN_BITS-1:0] first_number;
		logic [IN_BITS-1:0] second_number;
	} in_item_t;

	// One result item: flag and both divisor sums.
	typedef struct packed {
		logic                    is_amicable;
		logic [SUM_BITS_OUT-1:0] first_divisor_sum;
		logic [SUM_BITS_OUT-1:0] second_divisor_sum;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new pair and start on the first number
		logic next_num;  // switch to the second number
		logic div_step;  // one restoring division step
		logic acc;       // add the trial divisor if it divides, advance it
		logic publish;   // move the sums and flag into the output register
	} apt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trial_below; // trial divisor is still below the current number
		logic div_last;    // the division step in progress is the last one
		logic second_sel;  // working on the second number
		logic out_free;    // output register can take a result this cycle
	} apt_status_t;

endpackage

[src/apt_ctrl.sv]
// ----------------------------------------------------------------------------
// apt_ctrl
// Controller state machine: sequences the trial divisions for both numbers.
// ----------------------------------------------------------------------------
module apt_ctrl import apt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  apt_status_t status,
	output apt_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (status.trial_below) begin
					state_d = ST_DIV;
				end else if (!status.second_sel) begin
					cmd.next_num = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/apt_datapath.sv]
// ----------------------------------------------------------------------------
// apt_datapath
// Operand registers, serial remainder unit, sum accumulators, output register.
// ----------------------------------------------------------------------------
module apt_datapath import apt_pkg::*; #(
	parameter int VALUE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_item,
	input  apt_cmd_t    cmd,
	output apt_status_t status,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	localparam int SUM_BITS = VALUE_BITS + SUM_EXTRA;
	localparam int IDX_BITS = $clog2(VALUE_BITS);
	localparam logic [IDX_BITS-1:0] IDX_TOP = IDX_BITS'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] num_a_q;
	logic [VALUE_BITS-1:0] num_b_q;
	logic                  sel_q;
	logic [VALUE_BITS-1:0] trial_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [SUM_BITS-1:0]   sum_a_q;
	logic [SUM_BITS-1:0]   sum_b_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [VALUE_BITS+IN_BITS-1:0] a_ext;
	logic [VALUE_BITS+IN_BITS-1:0] b_ext;
	logic [VALUE_BITS-1:0]         cur_num;
	logic [VALUE_BITS:0]           rem_shift;
	logic [VALUE_BITS:0]           rem_diff;
	logic [VALUE_BITS-1:0]         rem_next;
	logic [SUM_BITS-1:0]           trial_ext;
	logic [SUM_BITS+SUM_BITS_OUT-1:0] sum_a_wide;
	logic [SUM_BITS+SUM_BITS_OUT-1:0] sum_b_wide;
	logic                          hit;

	// Input numbers are taken modulo 2^VALUE_BITS.
	assign a_ext = {{VALUE_BITS{1'b0}}, in_item.first_number};
	assign b_ext = {{VALUE_BITS{1'b0}}, in_item.second_number};

	// Number currently being divided.
	assign cur_num = sel_q ? num_b_q : num_a_q;

	// One restoring division step: bring down the next dividend bit.
	assign rem_shift = {rem_q, cur_num[idx_q]};
	assign rem_diff  = rem_shift - {1'b0, trial_q};
	assign rem_next  = rem_diff[VALUE_BITS] ? rem_shift[VALUE_BITS-1:0]
	                                        : rem_diff[VALUE_BITS-1:0];

	assign trial_ext = {{SUM_EXTRA{1'b0}}, trial_q};

	// Status toward the controller.
	assign status.trial_below = (trial_q < cur_num);
	assign status.div_last    = (idx_q == '0);
	assign status.second_sel  = sel_q;
	assign status.out_free    = !out_valid_q || out_ready;

	// Work registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_a_q <= '0;
			num_b_q <= '0;
			sel_q   <= 1'b0;
			trial_q <= VALUE_BITS'(1);
			rem_q   <= '0;
			idx_q   <= IDX_TOP;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (cmd.load) begin
			num_a_q <= a_ext[VALUE_BITS-1:0];
			num_b_q <= b_ext[VALUE_BITS-1:0];
			sel_q   <= 1'b0;
			trial_q <= VALUE_BITS'(1);
			rem_q   <= '0;
			idx_q   <= IDX_TOP;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (cmd.next_num) begin
			sel_q   <= 1'b1;
			trial_q <= VALUE_BITS'(1);
			rem_q   <= '0;
			idx_q   <= IDX_TOP;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			idx_q <= idx_q - IDX_BITS'(1);
		end else if (cmd.acc) begin
			if (rem_q == '0) begin
				if (sel_q) begin
					sum_b_q <= sum_b_q + trial_ext;
				end else begin
					sum_a_q <= sum_a_q + trial_ext;
				end
			end
			trial_q <= trial_q + VALUE_BITS'(1);
			rem_q   <= '0;
			idx_q   <= IDX_TOP;
		end
	end

	// Flag: each sum equals the other number and the numbers differ.
	assign hit = (sum_a_q == {{SUM_EXTRA{1'b0}}, num_b_q})
	          && (sum_b_q == {{SUM_EXTRA{1'b0}}, num_a_q})
	          && (num_a_q != num_b_q);

	assign sum_a_wide = {{SUM_BITS_OUT{1'b0}}, sum_a_q};
	assign sum_b_wide = {{SUM_BITS_OUT{1'b0}}, sum_b_q};

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_q.is_amicable        <= hit;
			out_q.first_divisor_sum  <= sum_a_wide[SUM_BITS_OUT-1:0];
			out_q.second_divisor_sum <= sum_b_wide[SUM_BITS_OUT-1:0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[src/amicable_pair_tester_top.sv]
// Each trial divisor costs a check, VALUE_BITS serial remainder steps and an add;
// a number n above one takes n-1 trials.
// A new pair is taken only once the previous result has been published; a finished
// item waits in the output register, stalling the next one.
// Reset (arst_n low) returns the controller to idle and empties the output.
// ----------------------------------------------------------------------------
// amicable_pair_tester_top
// Computes the proper divisor sums of a pair of numbers and flags amicable
// pairs, using a controller and a serial-division datapath.
// ----------------------------------------------------------------------------
module amicable_pair_tester_top import apt_pkg::*; #(
	parameter int VALUE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	apt_cmd_t    cmd;
	apt_status_t status;

	// Sequencer.
	apt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and result storage.
	apt_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

[sim/amicable_pair_checker.sv]
// ----------------------------------------------------------------------------
// amicable_pair_checker
// Watches both channels of the amicable pair tester. It works out the divisor
// sums and the flag for every accepted pair, and it compares each result item
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module amicable_pair_checker import apt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_item,
	output int        mismatch_count,
	output int        results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted result items, oldest first.
	out_item_t predicted_results_q[$];

	// Sum of the proper divisors of n at full width, found by pairing each
	// divisor up to the square root with its cofactor.
	function automatic logic [31:0] proper_divisor_sum(input logic [IN_BITS-1:0] n);
		logic [31:0] total;
		logic [31:0] divisor;
		logic [31:0] cofactor;
		logic [31:0] wide_n;
		wide_n = 32'(n);
		if (wide_n <= 1) begin
			return '0;
		end
		total = 1;
		for (divisor = 2; divisor * divisor <= wide_n; divisor++) begin
			if (wide_n % divisor == 0) begin
				cofactor = wide_n / divisor;
				total += divisor;
				if (cofactor != divisor) begin
					total += cofactor;
				end
			end
		end
		return total;
	endfunction

	// The flag compares the full sums; the result fields keep the low bits.
	function automatic out_item_t predict_pair_result(input in_item_t pair);
		logic [31:0] first_sum;
		logic [31:0] second_sum;
		out_item_t   result;
		first_sum  = proper_divisor_sum(pair.first_number);
		second_sum = proper_divisor_sum(pair.second_number);
		result.is_amicable = (first_sum == 32'(pair.second_number)) &&
			(second_sum == 32'(pair.first_number)) &&
			(pair.first_number != pair.second_number);
		result.first_divisor_sum  = first_sum[SUM_BITS_OUT-1:0];
		result.second_divisor_sum = second_sum[SUM_BITS_OUT-1:0];
		return result;
	endfunction

	// Compare finished items first, then queue the prediction for a new pair.
	always @(posedge clk or negedge arst_n) begin
		out_item_t predicted;
		int        new_errors;
		if (!arst_n) begin
			predicted_results_q.delete();
			mismatch_count  <= 0;
			results_pending <= 0;
		end else begin
			new_errors = 0;
			if (out_valid && out_ready) begin
				if (predicted_results_q.size() == 0) begin
					$error("result item with none outstanding: %p", out_item);
					new_errors++;
				end else begin
					predicted = predicted_results_q.pop_front();
					if (out_item.is_amicable !== predicted.is_amicable) begin
						$error("is_amicable: expected %0d, got %0d",
							predicted.is_amicable, out_item.is_amicable);
						new_errors++;
					end
					if (out_item.first_divisor_sum !== predicted.first_divisor_sum) begin
						$error("first_divisor_sum: expected %0d, got %0d",
							predicted.first_divisor_sum, out_item.first_divisor_sum);
						new_errors++;
					end
					if (out_item.second_divisor_sum !== predicted.second_divisor_sum) begin
						$error("second_divisor_sum: expected %0d, got %0d",
							predicted.second_divisor_sum, out_item.second_divisor_sum);
						new_errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predicted_results_q.push_back(predict_pair_result(in_item));
			end
			mismatch_count  <= mismatch_count + new_errors;
			results_pending <= predicted_results_q.size();
		end
	end

endmodule

[sim/tb_amicable_pair_tester_top.sv]
// ----------------------------------------------------------------------------
// tb_amicable_pair_tester_top
// Drives pairs into the amicable pair tester: a directed set with zero, one,
// perfect numbers, known amicable pairs, near misses and the widest values,
// then random pairs that are mostly small, with amicable and perfect numbers
// mixed in. Both sides idle at random; the receiver also holds off once for
// a long stretch. The checker beside the block reports mismatches.
// ----------------------------------------------------------------------------
module tb_amicable_pair_tester_top;
	timeunit 1ns;
	timeprecision 1ps;

	import apt_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 40_000_000;
	localparam int unsigned HOLD_CYCLES    = 40_000;
	localparam int unsigned RANDOM_ITEMS   = 81;
	localparam int unsigned DRAIN_TAIL     = 1000;
	localparam int unsigned DIRECTED_COUNT = 19;

	// Directed pairs, small ones first; the widest values come last.
	localparam in_item_t DIRECTED_PAIRS [DIRECTED_COUNT] = '{
		'{16'd0,     16'd0},
		'{16'd1,     16'd1},
		'{16'd0,     16'd1},
		'{16'd1,     16'd0},
		'{16'd2,     16'd3},
		'{16'd6,     16'd6},
		'{16'd28,    16'd28},
		'{16'd6,     16'd7},
		'{16'd12,    16'd16},
		'{16'd220,   16'd284},
		'{16'd284,   16'd220},
		'{16'd220,   16'd285},
		'{16'd284,   16'd284},
		'{16'd496,   16'd496},
		'{16'd1184,  16'd1210},
		'{16'd1210,  16'd1184},
		'{16'd2620,  16'd2924},
		'{16'd27720, 16'd19064},
		'{16'd65535, 16'd65535}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	int          mismatch_count;
	int          results_pending;
	int unsigned cycle_count = 0;
	logic        hold_request = 1'b0;
	logic        steady_stream = 1'b0;

	amicable_pair_tester_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	amicable_pair_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Give up once the run has gone far past its slowest correct length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one pair and hold it until the block takes it.
	task automatic offer_pair(input logic [IN_BITS-1:0] first_value,
		input logic [IN_BITS-1:0] second_value);
		in_item  <= '{first_number: first_value, second_number: second_value};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Sometimes leave the input idle.
	task automatic sender_gap();
		int unsigned gap;
		if (!steady_stream && $urandom_range(99) < 20) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) begin
				@(posedge clk);
			end
		end
	endtask

	// Stop offering until every outstanding result item has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver: random back-pressure, one long hold-off, and a steady window.
	initial begin
		bit          hold_served;
		int unsigned held;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				out_ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++) begin
					@(posedge clk);
				end
			end else if (steady_stream) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 20);
			end
		end
	end

	// Sender: reset, directed pairs, random pairs, then the verdict.
	initial begin
		logic [IN_BITS-1:0] first_value;
		logic [IN_BITS-1:0] second_value;
		int unsigned        kind;
		repeat (2) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			offer_pair(DIRECTED_PAIRS[i].first_number, DIRECTED_PAIRS[i].second_number);
			sender_gap();
		end
		wait_for_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady_stream <= (i >= 50 && i < 70);
			if (i == 20) begin
				hold_request <= 1'b1;
			end
			if (i == 40) begin
				wait_for_results();
			end
			kind = $urandom_range(99);
			if (kind < 30) begin
				// A true amicable pair in either order.
				if ($urandom_range(9) == 0) begin
					first_value  = 16'd1184;
					second_value = 16'd1210;
				end else begin
					first_value  = 16'd220;
					second_value = 16'd284;
				end
				if ($urandom_range(1) == 1) begin
					{first_value, second_value} = {second_value, first_value};
				end
			end else if (kind < 40) begin
				// A perfect number paired with itself must not set the flag.
				case ($urandom_range(2))
					0: first_value = 16'd6;
					1: first_value = 16'd28;
					default: first_value = 16'd496;
				endcase
				second_value = first_value;
			end else if (kind < 50) begin
				// One member of a pair with a random partner.
				first_value  = ($urandom_range(1) == 1) ? 16'd220 : 16'd284;
				second_value = IN_BITS'($urandom_range(300));
				if ($urandom_range(1) == 1) begin
					{first_value, second_value} = {second_value, first_value};
				end
			end else if (kind < 55) begin
				first_value  = IN_BITS'($urandom_range(2047));
				second_value = IN_BITS'($urandom_range(2047));
			end else begin
				first_value  = IN_BITS'($urandom_range(255));
				second_value = IN_BITS'($urandom_range(255));
			end
			offer_pair(first_value, second_value);
			sender_gap();
		end

		wait_for_results();
		repeat (DRAIN_TAIL) begin
			@(posedge clk);
		end
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
src/apt_pkg.sv
src/apt_ctrl.sv
src/apt_datapath.sv
src/amicable_pair_tester_top.sv
sim/amicable_pair_checker.sv
sim/tb_amicable_pair_tester_top.sv
